// ===== src/bim_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the block-set interleave map.
// Used by the channel payloads, the divider and the top level.
package bim_pkg;

	localparam int MAX_CHUNKS = 64;
	localparam int TBL_DEPTH  = MAX_CHUNKS + 1;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);

	localparam int IDX_W      = 7;
	localparam int BND_W      = 48;
	localparam int SET_W      = 40;
	localparam int SLICE_W    = 16;
	localparam int CCNT_W     = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam int DIV_W      = 48;
	localparam int DIV_CNT_W  = $clog2(DIV_W);

	localparam logic [CFG_IDX_W-1:0] CFG_SLICE_LBAS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_COUNT = 1'd1;

	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [BND_W-1:0]  boundary_lba;
		logic [SET_W-1:0]  set_index;
	} in_item_t;

	typedef struct packed {
		logic [SET_W-1:0]  entry_out;
		logic              out_of_range;
		logic              misaligned;
	} out_item_t;

	typedef struct packed {
		logic              start;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_W-1:0]  quot;
		logic [DIV_W-1:0]  rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_LO,
		S_MUL_HI,
		S_SCAN,
		S_DIV_GO,
		S_DIV_WAIT,
		S_SPLIT,
		S_POS,
		S_OFF,
		S_SUM,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		DOP_LEN,
		DOP_START,
		DOP_GROUP,
		DOP_POS
	} div_op_t;

endpackage

// ===== src/bim_chan_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload beat of type T.
// Payload types come from bim_pkg at the place of instantiation.
interface bim_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bim_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// Stand-alone; no package needed.
module bim_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== src/bim_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bim_pkg for the request and response structs.
module bim_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bim_pkg::div_req_t req,
	output bim_pkg::div_rsp_t rsp
);
	import bim_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     den_q;
	logic [DIV_W:0]       rem_sh;
	logic [DIV_W:0]       diff;

	assign rem_sh = {rem_q, quo_q[DIV_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			// keep the difference when it does not borrow
			if (!diff[DIV_W]) begin
				rem_q <= diff[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;
endmodule

// ===== src/blockset_interleave_map.sv =====
`timescale 1ns / 1ps
// Block-set interleave map. Item beats with cmd 0 write one chunk boundary into
// the boundary table if the index is at most MAX_CHUNKS (no result); cmd 1
// translates a block set into a metadata entry index and gives one result beat.
// A translate forms the 60-bit LBA product in two halves (S_MUL_LO, S_MUL_HI),
// reads one boundary-table entry per cycle while scanning for the chunk c that
// holds the set, and runs four divisions on a shared bit-serial 48-bit divider
// (three for a tail set of a chunk with no full row). A set that no chunk holds
// goes to the output right after the scan. One item is in work at a time; a
// finished result waits in the output register while the next item is taken.
// Depends on bim_pkg, bim_chan_if, bim_ram, bim_div.
module blockset_interleave_map #(
	parameter int SLICES_PER_SET    = 8,
	parameter int ENTRIES_PER_GROUP = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bim_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bim_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	bim_chan_if.sink                          item,
	bim_chan_if.source                        result
);
	import bim_pkg::*;

	localparam int SPS_W  = $clog2(SLICES_PER_SET + 1);
	localparam int SS_W   = SLICE_W + SPS_W;
	localparam int HALF_W = SET_W / 2;
	localparam int PL_W   = HALF_W + SS_W;
	localparam int LBA_W  = SET_W + SS_W;
	localparam int E_W    = $clog2(ENTRIES_PER_GROUP);

	state_t state_q, state_d;
	div_op_t div_op_q;

	logic [SLICE_W-1:0] slice_q;
	logic [CCNT_W-1:0]  ccnt_q;
	logic [SLICE_W-1:0] slice_eff;
	logic [CCNT_W-1:0]  ncnt_d;
	logic [CCNT_W-1:0]  ncnt_q;

	logic [SET_W-1:0]   set_q;
	logic [SS_W-1:0]    set_size_q;
	logic [PL_W-1:0]    prod_lo_q;
	logic [PL_W-1:0]    prod_hi;
	logic [LBA_W-1:0]   lba_q;

	logic [TBL_AW:0]    scan_q;
	logic               pend_q;
	logic [TBL_AW:0]    pend_idx_q;
	logic [BND_W-1:0]   prev_q;
	logic               scan_hit;
	logic               scan_miss;

	logic [BND_W-1:0]   start_q;
	logic [BND_W-1:0]   end_q;
	logic [DIV_W-1:0]   nsets_q;
	logic [SET_W-1:0]   first_set_q;
	logic               mis_q;
	logic               oor_q;
	logic [DIV_W-1:0]   q_q;
	logic [E_W-1:0]     r_q;
	logic [DIV_W-1:0]   q_plus;
	logic [DIV_W-1:0]   split_q;
	logic [SET_W-1:0]   pos_q;
	logic [SET_W-1:0]   p2;
	logic               pos_lt;
	logic [SET_W-1:0]   num_q;
	logic [DIV_W-1:0]   den_q;
	logic               br_lo_q;
	logic [SET_W-1:0]   dq_q;
	logic [SET_W-1:0]   dr_q;
	logic [SET_W-1:0]   off_q;
	logic [SET_W-1:0]   entry_q;

	logic               item_acc;
	logic               item_ready;
	logic               tbl_we;
	logic               tbl_re;
	logic [BND_W-1:0]   tbl_rdata;
	logic               out_free;
	logic               out_load;
	logic               out_valid_q;
	out_item_t          out_data_q;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	bim_ram #(
		.WIDTH(BND_W),
		.DEPTH(TBL_DEPTH)
	) u_tbl (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (TBL_AW'(item.data.entry_index)),
		.wdata (item.data.boundary_lba),
		.re    (tbl_re),
		.raddr (scan_q[TBL_AW-1:0]),
		.rdata (tbl_rdata)
	);

	bim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign slice_eff = (slice_q == '0) ? SLICE_W'(1) : slice_q;
	assign ncnt_d    = (ccnt_q > CCNT_W'(MAX_CHUNKS)) ? CCNT_W'(MAX_CHUNKS) : ccnt_q;
	assign item_acc  = item.valid && item_ready;
	assign out_free  = !out_valid_q || result.ready;

	assign prod_hi = PL_W'(set_q[SET_W-1:HALF_W]) * PL_W'(set_size_q);

	// chunk c = pend_idx - 1 holds the LBA when prev <= lba < this boundary
	assign scan_hit  = pend_q && (pend_idx_q != '0) &&
		(LBA_W'(prev_q) <= lba_q) && (lba_q < LBA_W'(tbl_rdata));
	assign scan_miss = pend_q && !scan_hit && (pend_idx_q == (TBL_AW + 1)'(ncnt_q));

	assign q_plus = q_q + DIV_W'(1);
	assign pos_lt = DIV_W'(pos_q) < split_q;
	assign p2     = pos_q - SET_W'(split_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_acc && item.data.cmd == CMD_TRANSLATE) begin
					state_d = S_MUL_LO;
				end
			end
			S_MUL_LO: state_d = S_MUL_HI;
			S_MUL_HI: state_d = (ncnt_q == '0) ? S_OUT : S_SCAN;
			S_SCAN: begin
				priority if (scan_hit) begin
					state_d = S_DIV_GO;
				end else if (scan_miss) begin
					state_d = S_OUT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					unique case (div_op_q)
						DOP_LEN, DOP_START: state_d = S_DIV_GO;
						DOP_GROUP:          state_d = S_SPLIT;
						DOP_POS:            state_d = S_OFF;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_SPLIT: state_d = S_POS;
			S_POS:   state_d = (pos_lt || q_q != '0) ? S_DIV_GO : S_SUM;
			S_OFF:   state_d = S_SUM;
			S_SUM:   state_d = S_OUT;
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		item_ready    = (state_q == S_IDLE);
		tbl_we        = item_acc && item.data.cmd == CMD_WRITE &&
			(item.data.entry_index <= IDX_W'(MAX_CHUNKS));
		tbl_re        = (state_q == S_SCAN) && (scan_q <= (TBL_AW + 1)'(ncnt_q));
		out_load      = (state_q == S_OUT) && out_free;
		div_req.start = (state_q == S_DIV_GO);
		div_req.num   = '0;
		div_req.den   = '0;
		unique case (div_op_q)
			DOP_LEN: begin
				div_req.num = end_q - start_q;
				div_req.den = DIV_W'(set_size_q);
			end
			DOP_START: begin
				div_req.num = start_q;
				div_req.den = DIV_W'(set_size_q);
			end
			DOP_GROUP: begin
				// chunk length over set size times group width gives nsets / E
				div_req.num = end_q - start_q;
				div_req.den = DIV_W'(set_size_q) * DIV_W'(ENTRIES_PER_GROUP);
			end
			DOP_POS: begin
				div_req.num = DIV_W'(num_q);
				div_req.den = den_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slice_q     <= SLICE_W'(1);
			ccnt_q      <= CCNT_W'(1);
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SLICE_LBAS:  slice_q <= cfg_wdata[SLICE_W-1:0];
					CFG_CHUNK_COUNT: ccnt_q  <= cfg_wdata[CCNT_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			pend_q <= tbl_re;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.entry_out    <= oor_q ? '0 : entry_q;
			out_data_q.out_of_range <= oor_q;
			out_data_q.misaligned   <= oor_q ? 1'b0 : mis_q;
		end
		if (tbl_re) begin
			pend_idx_q <= scan_q;
			scan_q     <= scan_q + 1'b1;
		end
		if (pend_q) begin
			prev_q <= tbl_rdata;
		end
		unique case (state_q)
			S_IDLE: begin
				set_q      <= item.data.set_index;
				set_size_q <= SS_W'({{SPS_W{1'b0}}, slice_eff}) * SS_W'(SLICES_PER_SET);
				ncnt_q     <= ncnt_d;
				oor_q      <= 1'b0;
			end
			S_MUL_LO: begin
				prod_lo_q <= PL_W'(set_q[HALF_W-1:0]) * PL_W'(set_size_q);
			end
			S_MUL_HI: begin
				lba_q  <= LBA_W'({prod_hi, {HALF_W{1'b0}}}) + LBA_W'(prod_lo_q);
				scan_q <= '0;
				if (ncnt_q == '0) begin
					oor_q <= 1'b1;
				end
			end
			S_SCAN: begin
				if (scan_hit) begin
					start_q  <= prev_q;
					end_q    <= tbl_rdata;
					div_op_q <= DOP_LEN;
				end else if (scan_miss) begin
					oor_q <= 1'b1;
				end
			end
			S_DIV_WAIT: begin
				if (div_rsp.done) begin
					unique case (div_op_q)
						DOP_LEN: begin
							nsets_q  <= div_rsp.quot;
							div_op_q <= DOP_START;
						end
						DOP_START: begin
							first_set_q <= div_rsp.quot[SET_W-1:0];
							mis_q       <= (div_rsp.rem != '0);
							div_op_q    <= DOP_GROUP;
						end
						DOP_GROUP: begin
							q_q <= div_rsp.quot;
							r_q <= E_W'(nsets_q - div_rsp.quot * DIV_W'(ENTRIES_PER_GROUP));
						end
						DOP_POS: begin
							dq_q <= div_rsp.quot[SET_W-1:0];
							dr_q <= div_rsp.rem[SET_W-1:0];
						end
						default: ;
					endcase
				end
			end
			S_SPLIT: begin
				split_q <= DIV_W'(r_q) * q_plus;
				pos_q   <= set_q - first_set_q;
			end
			S_POS: begin
				div_op_q <= DOP_POS;
				priority if (pos_lt) begin
					// leading columns hold q+1 entries
					num_q   <= pos_q;
					den_q   <= q_plus;
					br_lo_q <= 1'b1;
				end else if (q_q != '0) begin
					num_q   <= p2;
					den_q   <= q_q;
					br_lo_q <= 1'b0;
				end else begin
					// short chunk: tail sets run on in row 0
					off_q <= SET_W'(r_q) + p2;
				end
			end
			S_OFF: begin
				off_q <= SET_W'(dr_q * SET_W'(ENTRIES_PER_GROUP)) +
					(br_lo_q ? '0 : SET_W'(r_q)) + dq_q;
			end
			S_SUM: begin
				entry_q <= first_set_q + off_q;
			end
			default: ;
		endcase
	end

	assign item.ready   = item_ready;
	assign result.valid = out_valid_q;
	assign result.data  = out_data_q;
endmodule

// ===== bench/bim_map_scoreboard.sv =====
`timescale 1ns / 1ps
// Scoreboard for the block-set interleave map: tracks register writes and item beats,
// predicts the entry index of every translate and checks each result beat in order.
// Depends on bim_pkg for the item, result and register codes.
module bim_map_scoreboard
	import bim_pkg::*;
#(
	parameter int SLICES_PER_SET    = 8,
	parameter int ENTRIES_PER_GROUP = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  in_item_t              item_data,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  out_item_t             result_data,
	output int                    pending,
	output int                    fails
);

	logic [BND_W-1:0]   chunk_lba [0:TBL_DEPTH-1];
	logic [SLICE_W-1:0] slice_reg;
	logic [CCNT_W-1:0]  count_reg;
	out_item_t          want_entries [$];

	// Find the chunk of the set's first LBA, then place the set column by column.
	function automatic out_item_t map_set(input logic [SET_W-1:0] set_idx);
		logic [63:0] set_size, lba, base, span, n_sets, first_set, pos;
		logic [63:0] q, r, split, off, tail;
		int          live, c;
		bit          hit;
		out_item_t   res;
		set_size = ((slice_reg == '0) ? 64'd1 : 64'(slice_reg)) * 64'(SLICES_PER_SET);
		lba = 64'(set_idx) * set_size;
		live = (count_reg > MAX_CHUNKS) ? MAX_CHUNKS : int'(count_reg);
		res = '0;
		hit = 1'b0;
		c = 0;
		while (c < live && !hit) begin
			if (64'(chunk_lba[c]) <= lba && lba < 64'(chunk_lba[c+1]))
				hit = 1'b1;
			else
				c++;
		end
		if (!hit) begin
			res.out_of_range = 1'b1;
			return res;
		end
		base = 64'(chunk_lba[c]);
		span = 64'(chunk_lba[c+1]) - base;
		n_sets = span / set_size;
		first_set = base / set_size;
		pos = 64'(set_idx) - first_set;
		q = n_sets / 64'(ENTRIES_PER_GROUP);
		r = n_sets % 64'(ENTRIES_PER_GROUP);
		split = r * (q + 64'd1);
		if (pos < split) begin
			off = (pos % (q + 64'd1)) * 64'(ENTRIES_PER_GROUP) + pos / (q + 64'd1);
		end else begin
			tail = pos - split;
			// a chunk with no full row puts its tail sets straight after the r columns
			if (q == 64'd0)
				off = r + tail;
			else
				off = (tail % q) * 64'(ENTRIES_PER_GROUP) + r + tail / q;
		end
		res.entry_out = SET_W'(first_set + off);
		res.misaligned = (base % set_size) != 64'd0;
		return res;
	endfunction

	task automatic report(input string what, input out_item_t got, input out_item_t want);
		$display("%s: got entry %h oor %b mis %b, want entry %h oor %b mis %b", what,
			got.entry_out, got.out_of_range, got.misaligned,
			want.entry_out, want.out_of_range, want.misaligned);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			slice_reg = SLICE_W'(1);
			count_reg = CCNT_W'(1);
			want_entries.delete();
			pending <= 0;
		end else begin
			// check the result beat first so a same-edge translate cannot match it
			if (result_valid && result_ready) begin
				if (want_entries.size() == 0) begin
					report("result beat with nothing expected", result_data, '0);
				end else begin
					want = want_entries.pop_front();
					if (result_data.entry_out != want.entry_out ||
					    result_data.out_of_range != want.out_of_range ||
					    result_data.misaligned != want.misaligned)
						report("result mismatch", result_data, want);
				end
			end
			if (item_valid && item_ready) begin
				if (item_data.cmd == CMD_WRITE) begin
					// slots past the table are dropped
					if (item_data.entry_index <= MAX_CHUNKS)
						chunk_lba[item_data.entry_index] = item_data.boundary_lba;
				end else begin
					want_entries.push_back(map_set(item_data.set_index));
				end
			end
			if (cfg_we) begin
				if (cfg_index == CFG_SLICE_LBAS)
					slice_reg = cfg_wdata[SLICE_W-1:0];
				else if (cfg_index == CFG_CHUNK_COUNT)
					count_reg = cfg_wdata[CCNT_W-1:0];
			end
			pending <= want_entries.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Top of the interleave map bench: clock, reset, register writes, item stimulus with
// bursty traffic and a stalling receiver, plus the idle watchdog and the verdict.
// Depends on bim_pkg, bim_chan_if, blockset_interleave_map and bim_map_scoreboard.
module tb;
	import bim_pkg::*;

	localparam int SPS         = 8;
	localparam int EPG         = 32;
	localparam int LIMIT       = 20000;
	localparam int SETTLE      = 300;
	localparam int HOLD_AT     = 160;
	localparam int HOLD_CYCLES = 3000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int                    sb_pending;
	int                    sb_fails;

	bim_chan_if #(.T(in_item_t))  item_ch ();
	bim_chan_if #(.T(out_item_t)) result_ch ();

	// stimulus-side copy of the boundary table, used to aim translates and nudge boundaries
	logic [BND_W-1:0]   lba_map [0:TBL_DEPTH-1];
	logic [SLICE_W-1:0] cur_slice;
	logic [CCNT_W-1:0]  cur_count;
	int                 burst_left = 0;
	int                 gap = 0;
	int                 beats_sent = 0;

	always #5ns clk = ~clk;

	blockset_interleave_map #(
		.SLICES_PER_SET(SPS),
		.ENTRIES_PER_GROUP(EPG)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item(item_ch),
		.result(result_ch)
	);

	bim_map_scoreboard #(
		.SLICES_PER_SET(SPS),
		.ENTRIES_PER_GROUP(EPG)
	) scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_valid(item_ch.valid),
		.item_ready(item_ch.ready),
		.item_data(item_ch.data),
		.result_valid(result_ch.valid),
		.result_ready(result_ch.ready),
		.result_data(result_ch.data),
		.pending(sb_pending),
		.fails(sb_fails)
	);

	function automatic logic [63:0] set_size_now();
		return ((cur_slice == '0) ? 64'd1 : 64'(cur_slice)) * 64'(SPS);
	endfunction

	function automatic int live_chunks();
		return (cur_count > MAX_CHUNKS) ? MAX_CHUNKS : int'(cur_count);
	endfunction

	task automatic send_beat(input in_item_t b);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
			if (gap > 0) begin
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		item_ch.valid <= 1'b1;
		item_ch.data <= b;
		do @(posedge clk); while (!item_ch.ready);
		beats_sent++;
	endtask

	task automatic write_slot(input int idx, input logic [BND_W-1:0] v);
		in_item_t b;
		b.cmd = CMD_WRITE;
		b.entry_index = IDX_W'(idx);
		b.boundary_lba = v;
		b.set_index = SET_W'({$urandom, $urandom});
		send_beat(b);
		if (idx <= MAX_CHUNKS)
			lba_map[idx] = v;
	endtask

	task automatic translate(input logic [SET_W-1:0] s);
		in_item_t b;
		b.cmd = CMD_TRANSLATE;
		b.entry_index = IDX_W'($urandom);
		b.boundary_lba = BND_W'({$urandom, $urandom});
		b.set_index = s;
		send_beat(b);
	endtask

	// Drop valid, wait for every result, then let the bench settle.
	task automatic drain();
		item_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (sb_pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [SLICE_W-1:0] slice, input logic [CCNT_W-1:0] count);
		cfg_we <= 1'b1;
		cfg_index <= CFG_SLICE_LBAS;
		cfg_wdata <= CFG_DATA_W'(slice);
		@(posedge clk);
		// bits above the count are not part of the register
		cfg_index <= CFG_CHUNK_COUNT;
		cfg_wdata <= {9'($urandom), count};
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_slice = slice;
		cur_count = count;
		@(posedge clk);
	endtask

	function automatic logic [63:0] chunk_span(input logic [63:0] ss);
		logic [63:0] n_sets, span;
		case ($urandom_range(0, 4))
			0:       n_sets = $urandom_range(0, 2);
			1:       n_sets = $urandom_range(3, 31);
			2:       n_sets = $urandom_range(32, 200);
			3:       n_sets = $urandom_range(200, 5000);
			default: n_sets = $urandom_range(5000, 200000);
		endcase
		span = n_sets * ss;
		if ($urandom_range(0, 2) == 0)
			span += 64'($urandom) % ss;
		return span;
	endfunction

	// Non-decreasing boundaries for the live chunks and a closing boundary; slots above
	// keep what earlier phases left there.
	task automatic load_table();
		logic [63:0]      ss, pos;
		logic [BND_W-1:0] v;
		int               live;
		ss = set_size_now();
		live = live_chunks();
		pos = ss * 64'($urandom_range(0, 1000));
		if ($urandom_range(0, 3) == 0)
			pos += 64'($urandom) % ss;
		for (int i = 0; i <= live; i++) begin
			if (i < live) begin
				v = BND_W'(pos);
				pos += chunk_span(ss);
			end else begin
				v = ($urandom_range(0, 1) == 1) ?
					{BND_W{1'b1}} - BND_W'($urandom_range(0, 4095)) : BND_W'(pos);
			end
			write_slot(i, v);
		end
	endtask

	// Mostly sets inside a live chunk (first, last, anywhere), else sets just past the end or any set.
	function automatic logic [SET_W-1:0] pick_set();
		logic [63:0] ss, lo, hi, roll;
		int          live, c, kind;
		ss = set_size_now();
		live = live_chunks();
		kind = $urandom_range(0, 19);
		roll = {$urandom, $urandom};
		if (live > 0 && kind < 15) begin
			c = $urandom_range(0, live - 1);
			if (lba_map[c+1] > lba_map[c]) begin
				lo = (64'(lba_map[c]) + ss - 64'd1) / ss;
				hi = (64'(lba_map[c+1]) - 64'd1) / ss;
				if (lo <= hi) begin
					case (kind % 3)
						0:       return SET_W'(lo);
						1:       return SET_W'(hi);
						default: return SET_W'(lo + roll % (hi - lo + 64'd1));
					endcase
				end
			end
		end
		if (live > 0 && kind < 18)
			return SET_W'(64'(lba_map[live]) / ss + roll % 64'd4);
		return roll[SET_W-1:0];
	endfunction

	task automatic run_phase(input logic [SLICE_W-1:0] slice, input logic [CCNT_W-1:0] count,
			input int n);
		int               roll, idx;
		logic [BND_W-1:0] v;
		set_config(slice, count);
		load_table();
		repeat (n) begin
			roll = $urandom_range(0, 99);
			if (roll < 84) begin
				translate(pick_set());
			end else if (roll < 94) begin
				// disturb the table: nudge a boundary or scramble it
				idx = $urandom_range(0, MAX_CHUNKS);
				v = ($urandom_range(0, 1) == 1) ? BND_W'({$urandom, $urandom}) :
					lba_map[idx] + BND_W'($urandom_range(0, 64)) - BND_W'(32);
				write_slot(idx, v);
			end else begin
				write_slot($urandom_range(MAX_CHUNKS + 1, 127), BND_W'({$urandom, $urandom}));
			end
		end
		drain();
	endtask

	// Hand-built layout with set size 8: a short chunk, a multi-row chunk,
	// a chunk with a tail set and a misaligned chunk.
	task automatic directed_phase();
		set_config(SLICE_W'(1), CCNT_W'(4));
		write_slot(0, BND_W'(0));
		write_slot(1, BND_W'(40));
		write_slot(2, BND_W'(600));
		write_slot(3, BND_W'(627));
		write_slot(4, BND_W'(947));
		for (int i = 5; i < MAX_CHUNKS; i++)
			write_slot(i, BND_W'({$urandom, $urandom}));
		write_slot(MAX_CHUNKS, {BND_W{1'b1}});
		translate(SET_W'(0));
		translate(SET_W'(4));
		translate(SET_W'(5));
		translate(SET_W'(39));
		translate(SET_W'(74));
		translate(SET_W'(75));
		translate(SET_W'(77));
		translate(SET_W'(78));
		translate(SET_W'(79));
		translate(SET_W'(118));
		translate(SET_W'(119));
		translate({SET_W{1'b1}});
		write_slot(127, BND_W'({$urandom, $urandom}));
		write_slot(MAX_CHUNKS + 1, BND_W'({$urandom, $urandom}));
		translate(SET_W'(5));
		// overlap chunks 0 and 2: the lower chunk takes the set
		write_slot(2, BND_W'(20));
		translate(SET_W'(3));
		write_slot(4, {BND_W{1'b1}});
		translate({SET_W{1'b1}});
		translate(SET_W'(119));
		drain();
	endtask

	initial begin : receiver
		int run_left;
		int mode;
		int hold_left;
		bit hold_done;
		run_left = 0;
		mode = 0;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && beats_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				// hold off long enough for the block to back up its input
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (run_left == 0) begin
					mode = $urandom_range(0, 2);
					run_left = $urandom_range(10, 200);
				end
				run_left--;
				case (mode)
					0:       result_ch.ready <= 1'b1;
					1:       result_ch.ready <= ($urandom_range(0, 1) == 1);
					default: result_ch.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb NOT OK");
		$finish;
	end

	initial begin : stimulus
		cfg_we <= 1'b0;
		cfg_index <= CFG_SLICE_LBAS;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_phase();
		run_phase(SLICE_W'(1), CCNT_W'(64), 45);
		run_phase({SLICE_W{1'b1}}, CCNT_W'(127), 30);
		run_phase(SLICE_W'(0), CCNT_W'(10), 30);
		run_phase(SLICE_W'($urandom_range(1, 65535)), CCNT_W'(0), 10);
		repeat (2)
			run_phase(($urandom_range(0, 1) == 1) ? SLICE_W'($urandom_range(1, 16)) :
				SLICE_W'($urandom_range(1, 65535)), CCNT_W'($urandom_range(1, 64)), 25);
		if (sb_fails == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
src/bim_pkg.sv
src/bim_chan_if.sv
src/bim_ram.sv
src/bim_div.sv
src/blockset_interleave_map.sv
bench/bim_map_scoreboard.sv
bench/tb.sv
